>>> rtl/cbpf_pkg.sv
// shared types and constants for the cubic bezier path flattener
// command and status structs that join controller and datapath
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cbpf_pkg;

   localparam int CW         = 24;
   localparam int STEP_W     = 8;
   localparam int KIND_W     = 3;
   localparam int PK_W       = 2;
   localparam int MUL_W      = CW + 2;
   localparam logic [STEP_W-1:0] STEP_RESET = 8'd5;

   typedef enum logic [KIND_W-1:0] {
      KIND_MOVE  = 3'd0,
      KIND_LINE  = 3'd1,
      KIND_CURVE = 3'd2,
      KIND_CLOSE = 3'd3,
      KIND_CLEAR = 3'd4
   } kind_type;

   typedef enum logic [PK_W-1:0] {
      PK_MOVE   = 2'd0,
      PK_VERTEX = 2'd1,
      PK_CLOSE  = 2'd2
   } point_kind_type;

   typedef enum logic [1:0] {
      SEL_END   = 2'd0,
      SEL_CTRL1 = 2'd1,
      SEL_START = 2'd2,
      SEL_POINT = 2'd3
   } out_sel_type;

   typedef enum logic [2:0] {
      MUL_DX = 3'd0,
      MUL_DY = 3'd1,
      MUL_T0 = 3'd2,
      MUL_T1 = 3'd3,
      MUL_T2 = 3'd4,
      MUL_T3 = 3'd5
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD = 2'd0,
      ACC_LOAD = 2'd1,
      ACC_ADD  = 2'd2
   } acc_op_type;

   typedef struct packed {
      logic           in_load;
      logic           out_load;
      out_sel_type    out_sel;
      point_kind_type out_kind;
      logic           out_last;
      logic           pen_load;
      logic           start_load;
      logic           p0_load;
      mul_sel_type    mul_sel;
      acc_op_type     acc_op;
      logic           n_init;
      logic           n_inc;
      logic           i_init;
      logic           i_inc;
      logic           coef1;
      logic           coef2;
      logic           div_init;
      logic           div_step;
      logic           q_load;
      logic           axis;
   } cmd_type;

   typedef struct packed {
      logic d2_zero;
      logic search_done;
      logic i_eq_n;
      logic div_last;
   } status_type;

endpackage

`default_nettype wire

>>> rtl/cubic_bezier_path_flattener_core.sv
// top level of the cubic bezier path flattener
// joins cbpf_ctrl and cbpf_datapath; depends on cbpf_pkg
`timescale 1ns / 1ps
`default_nettype none

// req_ channel takes one path command (move, line, curve, close, clear);
// rsp_ channel returns the vertices it causes, rsp_last on the final one.
// csr_ channel writes flatten_step (reset value 5); write only while idle.
// one command is worked at a time; req_ready is high only when idle.
// move and line: the vertex is loaded into the output register in dispatch.
// close: two vertices when the subpath has two points or more, each waits for the receiver.
// curve: the distance is squared and summed first, then the segment search,
// then per point the coefficient steps C1 and C2, and per axis the multiply
// and accumulate states M0 to M3 and MA and a serial restoring divider;
// the divider takes most of the time of each point.
// a stalled receiver holds the vertex in the output register and freezes
// the sequencer. synchronous reset empties the path, zeroes pen and start.

module cubic_bezier_path_flattener_core #(
   parameter int MAX_SEGMENTS = 63,
   parameter int FRAC_BITS    = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [cbpf_pkg::KIND_W-1:0]        req_kind,
   input  wire logic signed [cbpf_pkg::CW-1:0]     req_ctrl1_x,
   input  wire logic signed [cbpf_pkg::CW-1:0]     req_ctrl1_y,
   input  wire logic signed [cbpf_pkg::CW-1:0]     req_ctrl2_x,
   input  wire logic signed [cbpf_pkg::CW-1:0]     req_ctrl2_y,
   input  wire logic signed [cbpf_pkg::CW-1:0]     req_end_x,
   input  wire logic signed [cbpf_pkg::CW-1:0]     req_end_y,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed [cbpf_pkg::CW-1:0]          rsp_point_x,
   output logic signed [cbpf_pkg::CW-1:0]          rsp_point_y,
   output logic [cbpf_pkg::PK_W-1:0]               rsp_point_kind,
   output logic                                    rsp_last,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [cbpf_pkg::STEP_W-1:0]        csr_flatten_step
);

   cbpf_pkg::cmd_type    cmd;
   cbpf_pkg::status_type status;

   assign csr_ready = 1'b1;

   cbpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cbpf_datapath #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .FRAC_BITS    (FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .csr_write (csr_valid & csr_ready),
      .csr_data  (csr_flatten_step),
      .in_c1x    (req_ctrl1_x),
      .in_c1y    (req_ctrl1_y),
      .in_c2x    (req_ctrl2_x),
      .in_c2y    (req_ctrl2_y),
      .in_ex     (req_end_x),
      .in_ey     (req_end_y),
      .out_x     (rsp_point_x),
      .out_y     (rsp_point_y),
      .out_kind  (rsp_point_kind),
      .out_last  (rsp_last)
   );

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input accepted while a vertex is pending");

   a_close_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_point_kind == cbpf_pkg::PK_CLOSE) |-> !rsp_last)
      else $error("close vertex marked last");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after a transfer");

endmodule

`default_nettype wire

>>> rtl/cbpf_datapath.sv
// datapath: coordinate registers, shared multiplier, accumulator,
// segment search, bezier coefficients and a restoring divider
// depends on cbpf_pkg
`timescale 1ns / 1ps
`default_nettype none

module cbpf_datapath #(
   parameter int MAX_SEGMENTS = 63,
   parameter int FRAC_BITS    = 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire cbpf_pkg::cmd_type                 cmd,
   output cbpf_pkg::status_type                   status,
   input  wire logic                              csr_write,
   input  wire logic [cbpf_pkg::STEP_W-1:0]       csr_data,
   input  wire logic signed [cbpf_pkg::CW-1:0]    in_c1x,
   input  wire logic signed [cbpf_pkg::CW-1:0]    in_c1y,
   input  wire logic signed [cbpf_pkg::CW-1:0]    in_c2x,
   input  wire logic signed [cbpf_pkg::CW-1:0]    in_c2y,
   input  wire logic signed [cbpf_pkg::CW-1:0]    in_ex,
   input  wire logic signed [cbpf_pkg::CW-1:0]    in_ey,
   output logic signed [cbpf_pkg::CW-1:0]         out_x,
   output logic signed [cbpf_pkg::CW-1:0]         out_y,
   output logic [cbpf_pkg::PK_W-1:0]              out_kind,
   output logic                                   out_last
);

   localparam int CW   = cbpf_pkg::CW;
   localparam int NW   = $clog2(MAX_SEGMENTS + 1);
   localparam int SNW  = cbpf_pkg::STEP_W + NW;
   localparam int CFW  = 3 * NW + 2;
   localparam int DW   = 3 * NW;
   localparam int MA   = cbpf_pkg::MUL_W;
   localparam int PW   = 2 * MA;
   localparam int ACCW = PW + 1;
   localparam int QB   = CW + 1;
   localparam int CNTW = $clog2(QB + 1);
   localparam int CMPW = 2 * SNW + 2 * FRAC_BITS + ACCW;

   logic [cbpf_pkg::STEP_W-1:0] step_ff;
   logic signed [CW-1:0] p1x_ff, p1y_ff, p2x_ff, p2y_ff, p3x_ff, p3y_ff;
   logic signed [CW-1:0] pen_x_ff, pen_y_ff, start_x_ff, start_y_ff;
   logic signed [CW-1:0] p0x_ff, p0y_ff, qx_ff, qy_ff;
   logic signed [CW:0]   dx_ff, dy_ff;
   logic signed [PW-1:0] prod_ff;
   logic signed [ACCW-1:0] acc_ff;
   logic [NW-1:0]   n_ff, i_ff;
   logic [SNW-1:0]  sn_ff;
   logic [2*NW-1:0] mm_ff, ii_ff, nn_ff;
   logic [CFW-1:0]  c0_ff, c1_ff, c2_ff, c3_ff;
   logic [DW-1:0]   den_ff;
   logic [DW:0]     rem_ff;
   logic [QB-1:0]   sh_ff;
   logic [CNTW-1:0] cnt_ff;
   logic            neg_ff;
   logic signed [CW-1:0] out_x_ff, out_y_ff;
   logic [cbpf_pkg::PK_W-1:0] out_kind_ff;
   logic out_last_ff;

   logic signed [CW-1:0] sel_x, sel_y;
   logic signed [MA-1:0] mul_a, mul_b;
   logic [NW-1:0]   m;
   logic [CFW-1:0]  mmi, iim;
   logic [2*SNW-1:0] sq;
   logic [CMPW-1:0] lhs, rhs;
   logic signed [ACCW-1:0] absn;
   logic [ACCW:0]   dvd;
   logic [DW:0]     divisor;
   logic [DW+1:0]   trial;
   logic            ge;
   logic [QB-1:0]   qres;

   always_comb begin
      case (cmd.out_sel)
         cbpf_pkg::SEL_END: begin
            sel_x = p3x_ff;
            sel_y = p3y_ff;
         end
         cbpf_pkg::SEL_CTRL1: begin
            sel_x = p1x_ff;
            sel_y = p1y_ff;
         end
         cbpf_pkg::SEL_START: begin
            sel_x = start_x_ff;
            sel_y = start_y_ff;
         end
         default: begin
            sel_x = qx_ff;
            sel_y = qy_ff;
         end
      endcase
   end

   always_comb begin
      case (cmd.mul_sel)
         cbpf_pkg::MUL_DX: begin
            mul_a = MA'(dx_ff);
            mul_b = MA'(dx_ff);
         end
         cbpf_pkg::MUL_DY: begin
            mul_a = MA'(dy_ff);
            mul_b = MA'(dy_ff);
         end
         cbpf_pkg::MUL_T0: begin
            mul_a = $signed(MA'(c0_ff));
            mul_b = MA'(cmd.axis ? p0y_ff : p0x_ff);
         end
         cbpf_pkg::MUL_T1: begin
            mul_a = $signed(MA'(c1_ff));
            mul_b = MA'(cmd.axis ? p1y_ff : p1x_ff);
         end
         cbpf_pkg::MUL_T2: begin
            mul_a = $signed(MA'(c2_ff));
            mul_b = MA'(cmd.axis ? p2y_ff : p2x_ff);
         end
         default: begin
            mul_a = $signed(MA'(c3_ff));
            mul_b = MA'(cmd.axis ? p3y_ff : p3x_ff);
         end
      endcase
   end

   assign m   = n_ff - i_ff;
   assign mmi = CFW'(mm_ff) * CFW'(i_ff);
   assign iim = CFW'(ii_ff) * CFW'(m);
   assign sq  = sn_ff * sn_ff;
   assign lhs = CMPW'(sq) << (2 * FRAC_BITS);
   assign rhs = CMPW'(acc_ff[ACCW-2:0]);

   assign absn    = acc_ff[ACCW-1] ? -acc_ff : acc_ff;
   assign dvd     = {absn, 1'b0} + (ACCW+1)'(den_ff);
   assign divisor = {den_ff, 1'b0};
   assign trial   = {rem_ff, sh_ff[QB-1]};
   assign ge      = trial >= {1'b0, divisor};
   assign qres    = neg_ff ? (~sh_ff + QB'(1)) : sh_ff;

   assign status.d2_zero     = (acc_ff == '0);
   assign status.search_done = (lhs >= rhs) || (n_ff >= NW'(MAX_SEGMENTS));
   assign status.i_eq_n      = (i_ff == n_ff);
   assign status.div_last    = (cnt_ff == CNTW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= cbpf_pkg::STEP_RESET;
         pen_x_ff   <= '0;
         pen_y_ff   <= '0;
         start_x_ff <= '0;
         start_y_ff <= '0;
      end else begin
         if (csr_write) begin
            step_ff <= csr_data;
         end
         if (cmd.pen_load) begin
            pen_x_ff <= sel_x;
            pen_y_ff <= sel_y;
         end
         if (cmd.start_load) begin
            start_x_ff <= sel_x;
            start_y_ff <= sel_y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.in_load) begin
         p1x_ff <= in_c1x;
         p1y_ff <= in_c1y;
         p2x_ff <= in_c2x;
         p2y_ff <= in_c2y;
         p3x_ff <= in_ex;
         p3y_ff <= in_ey;
      end
      if (cmd.p0_load) begin
         p0x_ff <= pen_x_ff;
         p0y_ff <= pen_y_ff;
         dx_ff  <= {p3x_ff[CW-1], p3x_ff} - {pen_x_ff[CW-1], pen_x_ff};
         dy_ff  <= {p3y_ff[CW-1], p3y_ff} - {pen_y_ff[CW-1], pen_y_ff};
      end
      prod_ff <= mul_a * mul_b;
      case (cmd.acc_op)
         cbpf_pkg::ACC_LOAD: acc_ff <= ACCW'(prod_ff);
         cbpf_pkg::ACC_ADD:  acc_ff <= acc_ff + ACCW'(prod_ff);
         default:            acc_ff <= acc_ff;
      endcase
      if (cmd.n_init) begin
         n_ff  <= NW'(1);
         sn_ff <= SNW'(step_ff);
      end else if (cmd.n_inc) begin
         n_ff  <= n_ff + NW'(1);
         sn_ff <= sn_ff + SNW'(step_ff);
      end
      if (cmd.i_init) begin
         i_ff <= NW'(1);
      end else if (cmd.i_inc) begin
         i_ff <= i_ff + NW'(1);
      end
      if (cmd.coef1) begin
         mm_ff <= (2*NW)'(m) * (2*NW)'(m);
         ii_ff <= (2*NW)'(i_ff) * (2*NW)'(i_ff);
         nn_ff <= (2*NW)'(n_ff) * (2*NW)'(n_ff);
      end
      if (cmd.coef2) begin
         c0_ff  <= CFW'(mm_ff) * CFW'(m);
         c1_ff  <= (mmi << 1) + mmi;
         c2_ff  <= (iim << 1) + iim;
         c3_ff  <= CFW'(ii_ff) * CFW'(i_ff);
         den_ff <= DW'(nn_ff) * DW'(n_ff);
      end
      if (cmd.div_init) begin
         rem_ff <= dvd[QB +: DW+1];
         sh_ff  <= dvd[QB-1:0];
         neg_ff <= acc_ff[ACCW-1];
         cnt_ff <= CNTW'(QB);
      end else if (cmd.div_step) begin
         rem_ff <= ge ? (DW+1)'(trial - {1'b0, divisor}) : trial[DW:0];
         sh_ff  <= {sh_ff[QB-2:0], ge};
         cnt_ff <= cnt_ff - CNTW'(1);
      end
      if (cmd.q_load) begin
         if (cmd.axis) begin
            qy_ff <= qres[CW-1:0];
         end else begin
            qx_ff <= qres[CW-1:0];
         end
      end
      if (cmd.out_load) begin
         out_x_ff    <= sel_x;
         out_y_ff    <= sel_y;
         out_kind_ff <= cmd.out_kind;
         out_last_ff <= cmd.out_last;
      end
   end

   assign out_x    = out_x_ff;
   assign out_y    = out_y_ff;
   assign out_kind = out_kind_ff;
   assign out_last = out_last_ff;

endmodule

`default_nettype wire

>>> rtl/cbpf_ctrl.sv
// controller: command dispatch, path flags and curve sequencing
// drives the datapath through cbpf_pkg::cmd_type
// depends on cbpf_pkg
`timescale 1ns / 1ps
`default_nettype none

module cbpf_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic [cbpf_pkg::KIND_W-1:0]   req_kind,
   output logic                               req_ready,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire cbpf_pkg::status_type          status,
   output cbpf_pkg::cmd_type                  cmd
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_DISPATCH, ST_EMIT, ST_CLOSE2, ST_CRV_P0, ST_CRV_SQX, ST_CRV_SQY,
      ST_CRV_SUM, ST_CRV_CHK, ST_SEARCH, ST_PT_C1, ST_PT_C2, ST_PT_M0, ST_PT_M1,
      ST_PT_M2, ST_PT_M3, ST_PT_MA, ST_DIV_INIT, ST_DIV_RUN, ST_DIV_END, ST_PT_EMIT
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;
   cbpf_pkg::kind_type kind_ff, kind_in;
   logic nonempty_ff, nonempty_in, pend_ff, pend_in, axis_ff, axis_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] sub_ff, sub_in, sub_sat;

   assign sub_sat = sub_ff[1] ? sub_ff : sub_ff + 2'd1;

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      kind_in      = kind_ff;
      nonempty_in  = nonempty_ff;
      pend_in      = pend_ff;
      axis_in      = axis_ff;
      sub_in       = sub_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.out_sel  = cbpf_pkg::SEL_END;
      cmd.out_kind = cbpf_pkg::PK_MOVE;
      cmd.mul_sel  = cbpf_pkg::MUL_DX;
      cmd.acc_op   = cbpf_pkg::ACC_HOLD;
      cmd.axis     = axis_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.in_load = 1'b1;
               kind_in     = cbpf_pkg::kind_type'(req_kind);
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            state_in = ST_IDLE;
            case (kind_ff)
               cbpf_pkg::KIND_MOVE, cbpf_pkg::KIND_LINE: begin
                  cmd.out_load = 1'b1;
                  cmd.out_last = 1'b1;
                  cmd.pen_load = 1'b1;
                  rsp_valid_in = 1'b1;
                  ret_in       = ST_IDLE;
                  state_in     = ST_EMIT;
                  if (kind_ff == cbpf_pkg::KIND_LINE && nonempty_ff) begin
                     cmd.out_kind = cbpf_pkg::PK_VERTEX;
                     sub_in       = sub_sat;
                  end else begin
                     cmd.start_load = 1'b1;
                     nonempty_in    = 1'b1;
                     sub_in         = 2'd1;
                  end
               end
               cbpf_pkg::KIND_CURVE: begin
                  state_in = ST_CRV_P0;
                  pend_in  = !nonempty_ff;
                  if (!nonempty_ff) begin
                     cmd.out_sel    = cbpf_pkg::SEL_CTRL1;
                     cmd.pen_load   = 1'b1;
                     cmd.start_load = 1'b1;
                     nonempty_in    = 1'b1;
                     sub_in         = 2'd1;
                  end
               end
               cbpf_pkg::KIND_CLOSE: begin
                  if (sub_ff[1]) begin
                     cmd.out_load = 1'b1;
                     cmd.out_sel  = cbpf_pkg::SEL_START;
                     cmd.out_kind = cbpf_pkg::PK_CLOSE;
                     rsp_valid_in = 1'b1;
                     ret_in       = ST_CLOSE2;
                     state_in     = ST_EMIT;
                  end
               end
               cbpf_pkg::KIND_CLEAR: begin
                  nonempty_in = 1'b0;
                  sub_in      = 2'd0;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = ret_ff;
            end
         end
         ST_CLOSE2: begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = cbpf_pkg::SEL_START;
            cmd.out_last = 1'b1;
            cmd.pen_load = 1'b1;
            rsp_valid_in = 1'b1;
            ret_in       = ST_IDLE;
            state_in     = ST_EMIT;
         end
         ST_CRV_P0: begin
            cmd.p0_load = 1'b1;
            state_in    = ST_CRV_SQX;
         end
         ST_CRV_SQX: begin
            cmd.mul_sel = cbpf_pkg::MUL_DX;
            state_in    = ST_CRV_SQY;
         end
         ST_CRV_SQY: begin
            cmd.mul_sel = cbpf_pkg::MUL_DY;
            cmd.acc_op  = cbpf_pkg::ACC_LOAD;
            state_in    = ST_CRV_SUM;
         end
         ST_CRV_SUM: begin
            cmd.acc_op = cbpf_pkg::ACC_ADD;
            cmd.n_init = 1'b1;
            state_in   = ST_CRV_CHK;
         end
         ST_CRV_CHK: begin
            if (pend_ff) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = cbpf_pkg::SEL_CTRL1;
               cmd.out_last = status.d2_zero;
               rsp_valid_in = 1'b1;
               ret_in       = status.d2_zero ? ST_IDLE : ST_SEARCH;
               state_in     = ST_EMIT;
            end else begin
               state_in = status.d2_zero ? ST_IDLE : ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (status.search_done) begin
               cmd.i_init = 1'b1;
               state_in   = ST_PT_C1;
            end else begin
               cmd.n_inc = 1'b1;
            end
         end
         ST_PT_C1: begin
            cmd.coef1 = 1'b1;
            state_in  = ST_PT_C2;
         end
         ST_PT_C2: begin
            cmd.coef2 = 1'b1;
            axis_in   = 1'b0;
            state_in  = ST_PT_M0;
         end
         ST_PT_M0: begin
            cmd.mul_sel = cbpf_pkg::MUL_T0;
            state_in    = ST_PT_M1;
         end
         ST_PT_M1: begin
            cmd.mul_sel = cbpf_pkg::MUL_T1;
            cmd.acc_op  = cbpf_pkg::ACC_LOAD;
            state_in    = ST_PT_M2;
         end
         ST_PT_M2: begin
            cmd.mul_sel = cbpf_pkg::MUL_T2;
            cmd.acc_op  = cbpf_pkg::ACC_ADD;
            state_in    = ST_PT_M3;
         end
         ST_PT_M3: begin
            cmd.mul_sel = cbpf_pkg::MUL_T3;
            cmd.acc_op  = cbpf_pkg::ACC_ADD;
            state_in    = ST_PT_MA;
         end
         ST_PT_MA: begin
            cmd.acc_op = cbpf_pkg::ACC_ADD;
            state_in   = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_DIV_END;
            end
         end
         ST_DIV_END: begin
            cmd.q_load = 1'b1;
            if (axis_ff) begin
               state_in = ST_PT_EMIT;
            end else begin
               axis_in  = 1'b1;
               state_in = ST_PT_M0;
            end
         end
         ST_PT_EMIT: begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = cbpf_pkg::SEL_POINT;
            cmd.out_kind = cbpf_pkg::PK_VERTEX;
            cmd.out_last = status.i_eq_n;
            cmd.pen_load = 1'b1;
            cmd.i_inc    = 1'b1;
            sub_in       = sub_sat;
            rsp_valid_in = 1'b1;
            ret_in       = status.i_eq_n ? ST_IDLE : ST_PT_C1;
            state_in     = ST_EMIT;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         kind_ff      <= cbpf_pkg::KIND_MOVE;
         nonempty_ff  <= 1'b0;
         pend_ff      <= 1'b0;
         axis_ff      <= 1'b0;
         sub_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         kind_ff      <= kind_in;
         nonempty_ff  <= nonempty_in;
         pend_ff      <= pend_in;
         axis_ff      <= axis_in;
         sub_ff       <= sub_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> dv/cbpf_checker.sv
// checker for the cubic bezier path flattener: watches the req_, rsp_ and csr_
// channels, predicts the vertices of each command and compares them in order
// depends on cbpf_pkg
`timescale 1ns / 1ps
`default_nettype none

module cbpf_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_ready,
   input  wire logic [cbpf_pkg::KIND_W-1:0]    req_kind,
   input  wire logic signed [cbpf_pkg::CW-1:0] req_ctrl1_x,
   input  wire logic signed [cbpf_pkg::CW-1:0] req_ctrl1_y,
   input  wire logic signed [cbpf_pkg::CW-1:0] req_ctrl2_x,
   input  wire logic signed [cbpf_pkg::CW-1:0] req_ctrl2_y,
   input  wire logic signed [cbpf_pkg::CW-1:0] req_end_x,
   input  wire logic signed [cbpf_pkg::CW-1:0] req_end_y,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   input  wire logic signed [cbpf_pkg::CW-1:0] rsp_point_x,
   input  wire logic signed [cbpf_pkg::CW-1:0] rsp_point_y,
   input  wire logic [cbpf_pkg::PK_W-1:0]      rsp_point_kind,
   input  wire logic                           rsp_last,
   input  wire logic                           csr_valid,
   input  wire logic                           csr_ready,
   input  wire logic [cbpf_pkg::STEP_W-1:0]    csr_flatten_step,
   output int                                  fail_count,
   output int                                  pending_count
);

   typedef struct {
      logic signed [cbpf_pkg::CW-1:0] x;
      logic signed [cbpf_pkg::CW-1:0] y;
      cbpf_pkg::point_kind_type       pk;
      logic                           last;
   } vertex_type;

   localparam int MAX_SEG = 63;

   vertex_type                    vertex_q[$];
   logic [cbpf_pkg::STEP_W-1:0]   step_reg;
   longint                        pen_x, pen_y, start_x, start_y;
   bit                            path_nonempty;
   int                            subpath_points;

   function automatic longint round_div(longint num, longint den);
      if (num >= 0) return (2 * num + den) / (2 * den);
      return -((-2 * num + den) / (2 * den));
   endfunction

   function automatic longint bezier_axis(longint n, longint i, longint p0, longint p1,
                                          longint p2, longint p3);
      longint m;
      m = n - i;
      return round_div(m * m * m * p0 + 3 * m * m * i * p1 + 3 * m * i * i * p2
                       + i * i * i * p3, n * n * n);
   endfunction

   task automatic push_vertex(longint x, longint y, cbpf_pkg::point_kind_type pk);
      vertex_type v;
      v.x = x[cbpf_pkg::CW-1:0];
      v.y = y[cbpf_pkg::CW-1:0];
      v.pk = pk;
      v.last = 1'b0;
      vertex_q.push_back(v);
   endtask

   task automatic move_to(longint x, longint y);
      push_vertex(x, y, cbpf_pkg::PK_MOVE);
      pen_x = x; pen_y = y; start_x = x; start_y = y;
      path_nonempty = 1; subpath_points = 1;
   endtask

   task automatic line_to(longint x, longint y);
      if (!path_nonempty) begin
         move_to(x, y);
      end else begin
         push_vertex(x, y, cbpf_pkg::PK_VERTEX);
         pen_x = x; pen_y = y;
         if (subpath_points < 2) subpath_points++;
      end
   endtask

   task automatic predict_command(logic [cbpf_pkg::KIND_W-1:0] kind, longint x1, longint y1,
                                  longint x2, longint y2, longint x3, longint y3);
      int     before_len;
      longint x0, y0, dx, dy, d2, st, n;
      before_len = vertex_q.size();
      case (kind)
         cbpf_pkg::KIND_MOVE: move_to(x3, y3);
         cbpf_pkg::KIND_LINE: line_to(x3, y3);
         cbpf_pkg::KIND_CURVE: begin
            if (!path_nonempty) move_to(x1, y1);
            x0 = pen_x; y0 = pen_y;
            dx = x3 - x0; dy = y3 - y0;
            d2 = dx * dx + dy * dy;
            if (d2 != 0) begin
               st = step_reg;
               for (n = 1; n < MAX_SEG; n++)
                  if (st * st * n * n * 65536 >= d2) break;
               for (longint i = 1; i <= n; i++)
                  line_to(bezier_axis(n, i, x0, x1, x2, x3),
                          bezier_axis(n, i, y0, y1, y2, y3));
            end
         end
         cbpf_pkg::KIND_CLOSE: begin
            if (subpath_points >= 2) begin
               push_vertex(start_x, start_y, cbpf_pkg::PK_CLOSE);
               push_vertex(start_x, start_y, cbpf_pkg::PK_MOVE);
               pen_x = start_x; pen_y = start_y;
            end
         end
         cbpf_pkg::KIND_CLEAR: begin
            path_nonempty = 0; subpath_points = 0;
         end
         default: ;
      endcase
      if (vertex_q.size() > before_len) vertex_q[$].last = 1'b1;
   endtask

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   always @(posedge clock) begin
      vertex_type e;
      if (reset) begin
         step_reg <= cbpf_pkg::STEP_RESET;
         pen_x = 0; pen_y = 0; start_x = 0; start_y = 0;
         path_nonempty = 0; subpath_points = 0;
         vertex_q.delete();
      end else begin
         if (csr_valid && csr_ready) step_reg <= csr_flatten_step;
         if (rsp_valid && rsp_ready) begin
            if (vertex_q.size() == 0) begin
               report_mismatch("vertex transfer with nothing expected");
            end else begin
               e = vertex_q.pop_front();
               if (rsp_point_x !== e.x)
                  report_mismatch($sformatf("point_x %0d exp %0d", rsp_point_x, e.x));
               if (rsp_point_y !== e.y)
                  report_mismatch($sformatf("point_y %0d exp %0d", rsp_point_y, e.y));
               if (rsp_point_kind !== e.pk)
                  report_mismatch($sformatf("point_kind %0d exp %0d", rsp_point_kind, e.pk));
               if (rsp_last !== e.last)
                  report_mismatch($sformatf("last %0b exp %0b", rsp_last, e.last));
            end
         end
         if (req_valid && req_ready)
            predict_command(req_kind, req_ctrl1_x, req_ctrl1_y, req_ctrl2_x, req_ctrl2_y,
                            req_end_x, req_end_y);
      end
      pending_count = vertex_q.size();
   end

   initial begin
      fail_count = 0;
      pending_count = 0;
   end

endmodule

`default_nettype wire

>>> dv/tb.sv
// testbench top for cubic_bezier_path_flattener_core: drives path commands
// and step register writes, random idling on both sides, gives the verdict
// depends on cbpf_pkg, cbpf_checker and the core
`timescale 1ns / 1ps
`default_nettype none

module tb;

   localparam int WATCHDOG_LIMIT = 200000;

   logic                              clock, reset;
   logic                              req_valid, req_ready;
   logic [cbpf_pkg::KIND_W-1:0]       req_kind;
   logic signed [cbpf_pkg::CW-1:0]    req_ctrl1_x, req_ctrl1_y, req_ctrl2_x, req_ctrl2_y;
   logic signed [cbpf_pkg::CW-1:0]    req_end_x, req_end_y;
   logic                              rsp_valid, rsp_ready;
   logic signed [cbpf_pkg::CW-1:0]    rsp_point_x, rsp_point_y;
   logic [cbpf_pkg::PK_W-1:0]         rsp_point_kind;
   logic                              rsp_last;
   logic                              csr_valid, csr_ready;
   logic [cbpf_pkg::STEP_W-1:0]       csr_flatten_step;
   int                                fail_count, pending_count;
   int                                idle_cycles;
   bit                                rsp_idling_on, hold_rsp;
   int                                hold_len;

   cubic_bezier_path_flattener_core i_dut (
      .clock, .reset, .req_valid, .req_ready, .req_kind,
      .req_ctrl1_x, .req_ctrl1_y, .req_ctrl2_x, .req_ctrl2_y, .req_end_x, .req_end_y,
      .rsp_valid, .rsp_ready, .rsp_point_x, .rsp_point_y, .rsp_point_kind, .rsp_last,
      .csr_valid, .csr_ready, .csr_flatten_step
   );

   cbpf_checker i_checker (
      .clock, .reset, .req_valid, .req_ready, .req_kind,
      .req_ctrl1_x, .req_ctrl1_y, .req_ctrl2_x, .req_ctrl2_y, .req_end_x, .req_end_y,
      .rsp_valid, .rsp_ready, .rsp_point_x, .rsp_point_y, .rsp_point_kind, .rsp_last,
      .csr_valid, .csr_ready, .csr_flatten_step, .fail_count, .pending_count
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // receiver: random stall bursts, or a long hold-off when asked
   initial begin
      int n;
      rsp_ready = 0;
      @(posedge clock iff !reset);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 0;
            repeat (hold_len) @(posedge clock);
            hold_rsp = 0;
         end else if (rsp_idling_on && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 15);
            rsp_ready <= 0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_ready <= 1;
            @(posedge clock);
         end
      end
   end

   function automatic logic signed [cbpf_pkg::CW-1:0] rand_coord(int mode);
      case (mode)
         0: return cbpf_pkg::CW'($urandom);
         1: return cbpf_pkg::CW'($signed($urandom_range(0, 8000)) - 4000);
         default: return cbpf_pkg::CW'($signed($urandom_range(0, 200000)) - 100000);
      endcase
   endfunction

   // valid stays high after a transfer unless a gap or a drain follows
   task automatic send_command(cbpf_pkg::kind_type kind,
                               logic signed [cbpf_pkg::CW-1:0] x1, y1, x2, y2, x3, y3,
                               bit gaps);
      int n;
      if (gaps && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 15);
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1;
      req_kind <= kind;
      req_ctrl1_x <= x1; req_ctrl1_y <= y1;
      req_ctrl2_x <= x2; req_ctrl2_y <= y2;
      req_end_x <= x3; req_end_y <= y3;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_drained;
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0 || !req_ready) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_step(logic [cbpf_pkg::STEP_W-1:0] v);
      wait_drained();
      csr_valid <= 1;
      csr_flatten_step <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
   endtask

   task automatic random_command(int mode, bit gaps);
      int                 r;
      cbpf_pkg::kind_type k;
      r = $urandom_range(0, 99);
      if (r < 10) k = cbpf_pkg::KIND_MOVE;
      else if (r < 35) k = cbpf_pkg::KIND_LINE;
      else if (r < 80) k = cbpf_pkg::KIND_CURVE;
      else if (r < 93) k = cbpf_pkg::KIND_CLOSE;
      else k = cbpf_pkg::KIND_CLEAR;
      if ($urandom_range(0, 49) == 0) k = cbpf_pkg::kind_type'($urandom_range(5, 7));
      send_command(k, rand_coord(mode), rand_coord(mode), rand_coord(mode),
                   rand_coord(mode), rand_coord(mode), rand_coord(mode), gaps);
   endtask

   initial begin
      logic [cbpf_pkg::STEP_W-1:0] steps[5];
      logic signed [cbpf_pkg::CW-1:0] mx, mn;
      steps = '{8'd255, 8'd1, 8'd37, 8'd0, 8'd5};
      mx = 24'sh7FFFFF; mn = 24'sh800000;
      reset = 1;
      req_valid = 0; req_kind = cbpf_pkg::KIND_MOVE;
      req_ctrl1_x = 0; req_ctrl1_y = 0; req_ctrl2_x = 0; req_ctrl2_y = 0;
      req_end_x = 0; req_end_y = 0;
      csr_valid = 0; csr_flatten_step = cbpf_pkg::STEP_RESET;
      rsp_idling_on = 0; hold_rsp = 0; hold_len = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty path cases, extremes, degenerate and repeated close
      send_command(cbpf_pkg::KIND_CLOSE, 0, 0, 0, 0, 0, 0, 0);
      send_command(cbpf_pkg::KIND_CURVE, 100, 200, 900, -300, 2000, 1500, 0);
      send_command(cbpf_pkg::KIND_CURVE, 0, 0, 0, 0, 100, 200, 0);
      send_command(cbpf_pkg::KIND_LINE, 0, 0, 0, 0, mx, mx, 0);
      send_command(cbpf_pkg::KIND_CLOSE, 0, 0, 0, 0, 0, 0, 0);
      send_command(cbpf_pkg::KIND_CLOSE, 0, 0, 0, 0, 0, 0, 0);
      send_command(cbpf_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0);
      send_command(cbpf_pkg::KIND_LINE, 0, 0, 0, 0, mn, mn, 0);
      send_command(cbpf_pkg::KIND_CURVE, mx, mn, mn, mx, mx, mx, 0);
      send_command(cbpf_pkg::KIND_CURVE, mn, mx, mx, mn, mn, mn, 0);
      send_command(cbpf_pkg::KIND_MOVE, 0, 0, 0, 0, -5, 7, 0);
      send_command(cbpf_pkg::KIND_CURVE, -300, 50, 20, -90, -5, 7, 0);
      send_command(cbpf_pkg::KIND_CLOSE, 0, 0, 0, 0, 0, 0, 0);
      send_command(cbpf_pkg::KIND_LINE, 0, 0, 0, 0, 24'sh7F0001, -24'sh0000FF, 0);
      send_command(cbpf_pkg::KIND_CLOSE, 0, 0, 0, 0, 0, 0, 0);
      send_command(cbpf_pkg::kind_type'(3'd5), 1, 2, 3, 4, 5, 6, 0);
      send_command(cbpf_pkg::kind_type'(3'd7), -1, -1, -1, -1, -1, -1, 0);
      send_command(cbpf_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0);
      send_command(cbpf_pkg::KIND_CURVE, -1, -1, 24'sh555555, 24'shAAAAAA, 1, 1, 0);

      // random phases across step settings, receiver stalls on
      rsp_idling_on = 1;
      foreach (steps[s]) begin
         write_step(steps[s]);
         for (int j = 0; j < 50; j++) random_command(j % 3, 1);
         if (s == 1) begin
            // long receiver hold-off while commands keep coming
            hold_len = 400;
            hold_rsp = 1;
            for (int j = 0; j < 6; j++) random_command(1, 0);
         end
         if (s == 2) wait_drained();
      end

      // last part without idling
      rsp_idling_on = 0;
      for (int j = 0; j < 30; j++) random_command(j % 3, 0);

      wait_drained();
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire
